FILE: rtl/core/bss_pkg.sv
// Shared types and constants for the branch unit station select block.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package bss_pkg;

    // Fixed widths of the item fields.
    localparam int REQ_W     = 2;
    localparam int STATION_W = 2;
    localparam int FLAGS_W   = 5;
    localparam int VALUE_W   = 32;
    localparam int TAG_W     = 4;

    // Bit positions within the flags field of a write item.
    localparam int FLAG_BUSY     = 0;
    localparam int FLAG_SRC1_RDY = 1;
    localparam int FLAG_SRC2_RDY = 2;
    localparam int FLAG_FRESH    = 3;
    localparam int FLAG_ISSUED   = 4;

    // Step to the next instruction when the branch falls through.
    localparam int NOT_TAKEN_STEP = 4;

    // Request codes carried by an item.
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_FLUSH = 2'd2
    } t_req;

    // Commands from the top level to the station table.
    typedef struct packed {
        logic write;
        logic tick;
    } t_slot_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/branch_unit_station_select_unit.sv
// Top level of the branch unit station select block: input register, result stage.
// Depends on bss_pkg, bss_stations and bss_resolve.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------------------
//  request  | in        | i_valid / o_stall  | i_req_type .. i_stall_hold
//  result   | out       | o_valid / i_stall  | o_result_valid .. o_picked_station
//
// One item is accepted per cycle while o_stall is low; its result passes through the input
// register, then the result stage written from the station scan and adder.
// Every item gives exactly one result, showing the result stage after the item.
// Reset is synchronous: all stations are empty, the stage is clear and the scan
// starts at station zero.
// While a result is stalled the input register holds its item and raises o_stall.
`default_nettype none

module branch_unit_station_select_unit import bss_pkg::*; #(
    parameter int STATIONS   = 4,
    parameter int ROB_DEPTH  = 16,
    parameter int DATA_WIDTH = 32,
    localparam int ST_W = (STATIONS > 1) ? $clog2(STATIONS) : 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire        [REQ_W-1:0]   i_req_type,
    input  wire        [STATION_W-1:0] i_station,
    input  wire        [FLAGS_W-1:0] i_flags,
    input  wire        [VALUE_W-1:0] i_src1_value,
    input  wire        [VALUE_W-1:0] i_src2_value,
    input  wire        [VALUE_W-1:0] i_base_addr,
    input  wire signed [VALUE_W-1:0] i_branch_offset,
    input  wire        [TAG_W-1:0]   i_dest_tag,
    input  wire                      i_stall_hold,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic                     o_result_valid,
    output logic                     o_branch_taken,
    output logic       [VALUE_W-1:0] o_target_addr,
    output logic       [TAG_W-1:0]   o_result_tag,
    output logic       [STATION_W-1:0] o_picked_station
);

    // Input register.
    logic                      r_in_valid;
    logic        [REQ_W-1:0]   r_in_req;
    logic        [STATION_W-1:0] r_in_station;
    logic        [FLAGS_W-1:0] r_in_flags;
    logic        [VALUE_W-1:0] r_in_src1;
    logic        [VALUE_W-1:0] r_in_src2;
    logic        [VALUE_W-1:0] r_in_base;
    logic signed [VALUE_W-1:0] r_in_offset;
    logic        [TAG_W-1:0]   r_in_tag;
    logic                      r_in_hold;

    // Result stage.
    logic                 r_out_valid;
    logic                 r_stage_valid;
    logic                 r_stage_taken;
    logic [VALUE_W-1:0]   r_stage_target;
    logic [TAG_W-1:0]     r_stage_tag;
    logic [STATION_W-1:0] r_stage_station;

    logic                 n_stage_valid;
    logic                 n_stage_taken;
    logic [VALUE_W-1:0]   n_stage_target;
    logic [TAG_W-1:0]     n_stage_tag;
    logic [STATION_W-1:0] n_stage_station;

    logic                  advance;
    logic                  is_tick;
    t_slot_cmd             cmd;
    logic                  pick_valid;
    logic [ST_W-1:0]       pick_idx;
    logic [DATA_WIDTH-1:0] pick_src1;
    logic [DATA_WIDTH-1:0] pick_src2;
    logic [DATA_WIDTH-1:0] pick_base;
    logic [DATA_WIDTH-1:0] pick_offset;
    logic [TAG_W-1:0]      pick_tag;
    logic                  res_taken;
    logic [VALUE_W-1:0]    res_target;

    // The held item moves on whenever the result stage is free or being taken.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    assign is_tick   = (r_in_req == REQ_TICK) && !r_in_hold;
    assign cmd.write = advance && (r_in_req == REQ_WRITE);
    assign cmd.tick  = advance && is_tick;

    bss_stations #(
        .STATIONS   (STATIONS),
        .ROB_DEPTH  (ROB_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_stations (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_station     (r_in_station),
        .i_flags       (r_in_flags),
        .i_src1        (r_in_src1),
        .i_src2        (r_in_src2),
        .i_base        (r_in_base),
        .i_offset      (r_in_offset),
        .i_tag         (r_in_tag),
        .o_pick_valid  (pick_valid),
        .o_pick_idx    (pick_idx),
        .o_pick_src1   (pick_src1),
        .o_pick_src2   (pick_src2),
        .o_pick_base   (pick_base),
        .o_pick_offset (pick_offset),
        .o_pick_tag    (pick_tag)
    );

    bss_resolve #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_resolve (
        .i_src1   (pick_src1),
        .i_src2   (pick_src2),
        .i_base   (pick_base),
        .i_offset (pick_offset),
        .o_taken  (res_taken),
        .o_target (res_target)
    );

    // Next stage contents for the item in the input register.
    always_comb begin
        n_stage_valid   = r_stage_valid;
        n_stage_taken   = r_stage_taken;
        n_stage_target  = r_stage_target;
        n_stage_tag     = r_stage_tag;
        n_stage_station = r_stage_station;
        case (r_in_req)
            REQ_TICK: begin
                if (!r_in_hold) begin
                    n_stage_valid   = pick_valid;
                    n_stage_taken   = pick_valid && res_taken;
                    n_stage_target  = pick_valid ? res_target : '0;
                    n_stage_tag     = pick_valid ? pick_tag : '0;
                    n_stage_station = pick_valid ? STATION_W'(pick_idx) : '0;
                end
            end
            REQ_FLUSH: begin
                n_stage_valid   = 1'b0;
                n_stage_taken   = 1'b0;
                n_stage_target  = '0;
                n_stage_tag     = '0;
                n_stage_station = '0;
            end
            default: begin
                // Writes and unknown requests leave the stage as it is.
            end
        endcase
    end

    // Input register: takes an item whenever it is not stalling.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_req     <= i_req_type;
            r_in_station <= i_station;
            r_in_flags   <= i_flags;
            r_in_src1    <= i_src1_value;
            r_in_src2    <= i_src2_value;
            r_in_base    <= i_base_addr;
            r_in_offset  <= i_branch_offset;
            r_in_tag     <= i_dest_tag;
            r_in_hold    <= i_stall_hold;
        end
    end

    // Result stage and its output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_stage_valid   <= 1'b0;
            r_stage_taken   <= 1'b0;
            r_stage_target  <= '0;
            r_stage_tag     <= '0;
            r_stage_station <= '0;
        end else if (advance) begin
            r_out_valid     <= 1'b1;
            r_stage_valid   <= n_stage_valid;
            r_stage_taken   <= n_stage_taken;
            r_stage_target  <= n_stage_target;
            r_stage_tag     <= n_stage_tag;
            r_stage_station <= n_stage_station;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_valid   = r_stage_valid;
    assign o_branch_taken   = r_stage_taken;
    assign o_target_addr    = r_stage_target;
    assign o_result_tag     = r_stage_tag;
    assign o_picked_station = r_stage_station;

endmodule

`default_nettype wire

FILE: rtl/core/bss_stations.sv
// Reservation station table with round-robin selection of the next branch.
// Depends on bss_pkg for field widths, flag positions and the command struct.
`default_nettype none

module bss_stations import bss_pkg::*; #(
    parameter int STATIONS   = 4,
    parameter int ROB_DEPTH  = 16,
    parameter int DATA_WIDTH = 32,
    localparam int ST_W = (STATIONS > 1) ? $clog2(STATIONS) : 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  t_slot_cmd                    i_cmd,
    input  wire        [STATION_W-1:0]   i_station,
    input  wire        [FLAGS_W-1:0]     i_flags,
    input  wire        [VALUE_W-1:0]     i_src1,
    input  wire        [VALUE_W-1:0]     i_src2,
    input  wire        [VALUE_W-1:0]     i_base,
    input  wire signed [VALUE_W-1:0]     i_offset,
    input  wire        [TAG_W-1:0]       i_tag,
    output logic                         o_pick_valid,
    output logic       [ST_W-1:0]        o_pick_idx,
    output logic       [DATA_WIDTH-1:0]  o_pick_src1,
    output logic       [DATA_WIDTH-1:0]  o_pick_src2,
    output logic       [DATA_WIDTH-1:0]  o_pick_base,
    output logic       [DATA_WIDTH-1:0]  o_pick_offset,
    output logic       [TAG_W-1:0]       o_pick_tag
);

    // Reduce a tag into the reorder buffer range by repeated subtraction.
    function automatic logic [TAG_W-1:0] wrap_tag(input logic [TAG_W-1:0] tag);
        logic [TAG_W-1:0] v;
        v = tag;
        for (int k = 0; k < 8; k++) begin
            if (32'(v) >= ROB_DEPTH) begin
                v = v - TAG_W'(ROB_DEPTH);
            end
        end
        return v;
    endfunction

    logic [STATIONS-1:0]   r_busy;
    logic [STATIONS-1:0]   r_rdy1;
    logic [STATIONS-1:0]   r_rdy2;
    logic [STATIONS-1:0]   r_fresh;
    logic [STATIONS-1:0]   r_issued;
    logic [DATA_WIDTH-1:0] r_src1   [STATIONS];
    logic [DATA_WIDTH-1:0] r_src2   [STATIONS];
    logic [DATA_WIDTH-1:0] r_base   [STATIONS];
    logic [DATA_WIDTH-1:0] r_offset [STATIONS];
    logic [TAG_W-1:0]      r_tag    [STATIONS];
    logic [ST_W-1:0]       r_last;

    logic [ST_W-1:0]     start;
    logic [STATIONS-1:0] eligible;
    logic [STATIONS-1:0] ge_start;
    logic [STATIONS-1:0] hi_req;
    logic [STATIONS-1:0] hi_grant;
    logic [STATIONS-1:0] lo_grant;
    logic [STATIONS-1:0] grant;
    logic [STATIONS-1:0] passed;
    logic [STATIONS-1:0] fresh_clr;
    logic                use_hi;
    logic                wr_en;
    logic [ST_W-1:0]     wr_idx;

    // The scan starts at the station after the last pick.
    assign start = (r_last == ST_W'(STATIONS - 1)) ? '0 : r_last + ST_W'(1);

    // A station can be picked when busy, not freshly woken, ready and issued.
    assign eligible = r_busy & ~r_fresh & r_rdy1 & r_rdy2 & r_issued;

    // Round-robin arbiter: lowest eligible at or above start, else lowest overall.
    assign ge_start = {STATIONS{1'b1}} << start;
    assign hi_req   = eligible & ge_start;
    assign use_hi   = |hi_req;
    assign hi_grant = hi_req & (~hi_req + STATIONS'(1));
    assign lo_grant = eligible & (~eligible + STATIONS'(1));
    assign grant    = use_hi ? hi_grant : lo_grant;

    // Stations the scan passes before reaching the pick (all of them when none
    // is picked, since grant minus one is then all ones).
    assign passed = use_hi ? (ge_start & (grant - STATIONS'(1)))
                           : (ge_start | (grant - STATIONS'(1)));
    assign fresh_clr = passed & r_busy & r_fresh;

    // Encode the one-hot grant.
    always_comb begin
        o_pick_idx = '0;
        for (int j = 0; j < STATIONS; j++) begin
            if (grant[j]) begin
                o_pick_idx = o_pick_idx | ST_W'(j);
            end
        end
    end

    assign o_pick_valid  = |eligible;
    assign o_pick_src1   = r_src1[o_pick_idx];
    assign o_pick_src2   = r_src2[o_pick_idx];
    assign o_pick_base   = r_base[o_pick_idx];
    assign o_pick_offset = r_offset[o_pick_idx];
    assign o_pick_tag    = r_tag[o_pick_idx];

    // Writes beyond the last station are dropped.
    assign wr_en  = i_cmd.write && (32'(i_station) < STATIONS);
    assign wr_idx = ST_W'(i_station);

    // Status flags and the round-robin pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= '0;
            r_rdy1   <= '0;
            r_rdy2   <= '0;
            r_fresh  <= '0;
            r_issued <= '0;
            r_last   <= ST_W'(STATIONS - 1);
        end else begin
            if (wr_en) begin
                r_busy[wr_idx]   <= i_flags[FLAG_BUSY];
                r_rdy1[wr_idx]   <= i_flags[FLAG_SRC1_RDY];
                r_rdy2[wr_idx]   <= i_flags[FLAG_SRC2_RDY];
                r_fresh[wr_idx]  <= i_flags[FLAG_FRESH];
                r_issued[wr_idx] <= i_flags[FLAG_ISSUED];
            end
            if (i_cmd.tick) begin
                r_fresh <= r_fresh & ~fresh_clr;
                if (o_pick_valid) begin
                    r_issued <= r_issued & ~grant;
                    r_last   <= o_pick_idx;
                end
            end
        end
    end

    // Operand and address storage; the offset is sign-extended to the data width.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_src1[wr_idx]   <= DATA_WIDTH'(i_src1);
            r_src2[wr_idx]   <= DATA_WIDTH'(i_src2);
            r_base[wr_idx]   <= DATA_WIDTH'(i_base);
            r_offset[wr_idx] <= DATA_WIDTH'(i_offset);
            r_tag[wr_idx]    <= wrap_tag(i_tag);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bss_resolve.sv
// Branch resolution: compares the operands and forms the next address.
// Depends on bss_pkg for the output width and the fall-through step.
`default_nettype none

module bss_resolve import bss_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire  [DATA_WIDTH-1:0] i_src1,
    input  wire  [DATA_WIDTH-1:0] i_src2,
    input  wire  [DATA_WIDTH-1:0] i_base,
    input  wire  [DATA_WIDTH-1:0] i_offset,
    output logic                  o_taken,
    output logic [VALUE_W-1:0]    o_target
);

    logic [DATA_WIDTH-1:0] addend;
    logic [DATA_WIDTH-1:0] sum;

    // The branch is taken when the operands differ.
    assign o_taken = (i_src1 != i_src2);

    // One adder, wrapping at the data width.
    assign addend   = o_taken ? i_offset : DATA_WIDTH'(NOT_TAKEN_STEP);
    assign sum      = i_base + addend;
    assign o_target = VALUE_W'(sum);

endmodule

`default_nettype wire

FILE: rtl/core/bss_checker.sv
// Port-level checks for the branch unit station select block, bound to its top level.
// Depends on bss_pkg for field widths.
`default_nettype none

module bss_checker import bss_pkg::*; #(
    parameter int STATIONS  = 4,
    parameter int ROB_DEPTH = 16
) (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_stall,
    input wire                 o_valid,
    input wire                 i_stall,
    input wire                 o_result_valid,
    input wire                 o_branch_taken,
    input wire [VALUE_W-1:0]   o_target_addr,
    input wire [TAG_W-1:0]     o_result_tag,
    input wire [STATION_W-1:0] o_picked_station
);

    // The input side only stalls when a result is waiting and itself stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the result stage could move");

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_valid)
            && $stable(o_branch_taken) && $stable(o_target_addr)
            && $stable(o_result_tag) && $stable(o_picked_station)))
        else $error("stalled result changed");

    // An empty stage shows all-zero fields.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_valid) |-> (!o_branch_taken && o_target_addr == '0
            && o_result_tag == '0 && o_picked_station == '0))
        else $error("empty stage with non-zero fields");

    // A resolved branch names a real station and reorder buffer entry.
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_valid) |-> ((32'(o_result_tag) < ROB_DEPTH)
            && (32'(o_picked_station) < STATIONS)))
        else $error("resolved branch outside station or tag range");

endmodule

bind branch_unit_station_select_unit bss_checker #(
    .STATIONS  (STATIONS),
    .ROB_DEPTH (ROB_DEPTH)
) u_bss_checker (.*);

`default_nettype wire

FILE: dv/branch_resolve_checker.sv
// Watches both channels of the branch unit station select block and predicts its results.
// Depends on bss_pkg for widths, flag positions and request codes.
`timescale 1ns / 1ps

module branch_resolve_checker import bss_pkg::*; (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    input  wire                       o_stall,
    input  wire       [REQ_W-1:0]     i_req_type,
    input  wire       [STATION_W-1:0] i_station,
    input  wire       [FLAGS_W-1:0]   i_flags,
    input  wire       [VALUE_W-1:0]   i_src1_value,
    input  wire       [VALUE_W-1:0]   i_src2_value,
    input  wire       [VALUE_W-1:0]   i_base_addr,
    input  wire       [VALUE_W-1:0]   i_branch_offset,
    input  wire       [TAG_W-1:0]     i_dest_tag,
    input  wire                       i_stall_hold,
    input  wire                       o_valid,
    input  wire                       i_stall,
    input  wire                       o_result_valid,
    input  wire                       o_branch_taken,
    input  wire       [VALUE_W-1:0]   o_target_addr,
    input  wire       [TAG_W-1:0]     o_result_tag,
    input  wire       [STATION_W-1:0] o_picked_station,
    output int                        o_mismatches,
    output int                        o_pending
);

    localparam int NUM_STATIONS = 4;

    // Contents of the result stage, as seen on the result channel.
    typedef struct packed {
        logic                 valid;
        logic                 taken;
        logic [VALUE_W-1:0]   target;
        logic [TAG_W-1:0]     tag;
        logic [STATION_W-1:0] station;
    } t_stage;

    // Predicted reservation station table.
    logic               stn_busy   [NUM_STATIONS];
    logic               stn_rdy1   [NUM_STATIONS];
    logic               stn_rdy2   [NUM_STATIONS];
    logic               stn_fresh  [NUM_STATIONS];
    logic               stn_issued [NUM_STATIONS];
    logic [VALUE_W-1:0] stn_src1   [NUM_STATIONS];
    logic [VALUE_W-1:0] stn_src2   [NUM_STATIONS];
    logic [VALUE_W-1:0] stn_base   [NUM_STATIONS];
    logic [VALUE_W-1:0] stn_off    [NUM_STATIONS];
    logic [TAG_W-1:0]   stn_tag    [NUM_STATIONS];

    logic [STATION_W-1:0] scan_last;
    t_stage               stage_now;
    t_stage               stage_queue [$];
    int                   mismatch_count = 0;

    // Empty table, clear stage, and the first scan starting at station zero.
    task automatic clear_prediction();
        int n;
        for (n = 0; n < NUM_STATIONS; n++) begin
            stn_busy[n]   = 1'b0;
            stn_rdy1[n]   = 1'b0;
            stn_rdy2[n]   = 1'b0;
            stn_fresh[n]  = 1'b0;
            stn_issued[n] = 1'b0;
            stn_src1[n]   = '0;
            stn_src2[n]   = '0;
            stn_base[n]   = '0;
            stn_off[n]    = '0;
            stn_tag[n]    = '0;
        end
        scan_last = STATION_W'(NUM_STATIONS - 1);
        stage_now = '0;
    endtask

    // Round-robin scan for one unheld tick. With four stations the index wraps by itself.
    task automatic resolve_tick();
        logic [STATION_W-1:0] idx;
        bit                   found;
        int                   n;
        idx       = scan_last + 1'b1;
        found     = 1'b0;
        stage_now = '0;
        for (n = 0; n < NUM_STATIONS && !found; n++) begin
            if (stn_busy[idx] && stn_fresh[idx]) begin
                // A station that has just received an operand waits one more tick.
                stn_fresh[idx] = 1'b0;
            end else if (stn_busy[idx] && stn_rdy1[idx] && stn_rdy2[idx] && stn_issued[idx]) begin
                found             = 1'b1;
                scan_last         = idx;
                stn_issued[idx]   = 1'b0;
                stage_now.valid   = 1'b1;
                stage_now.tag     = stn_tag[idx];
                stage_now.station = idx;
                if (stn_src1[idx] != stn_src2[idx]) begin
                    stage_now.taken  = 1'b1;
                    stage_now.target = stn_base[idx] + stn_off[idx];
                end else begin
                    stage_now.taken  = 1'b0;
                    stage_now.target = stn_base[idx] + VALUE_W'(NOT_TAKEN_STEP);
                end
            end
            idx = idx + 1'b1;
        end
    endtask

    // Apply the item on the request channel to the predicted state.
    task automatic apply_request();
        case (i_req_type)
            REQ_WRITE: begin
                stn_busy[i_station]   = i_flags[FLAG_BUSY];
                stn_rdy1[i_station]   = i_flags[FLAG_SRC1_RDY];
                stn_rdy2[i_station]   = i_flags[FLAG_SRC2_RDY];
                stn_fresh[i_station]  = i_flags[FLAG_FRESH];
                stn_issued[i_station] = i_flags[FLAG_ISSUED];
                stn_src1[i_station]   = i_src1_value;
                stn_src2[i_station]   = i_src2_value;
                stn_base[i_station]   = i_base_addr;
                stn_off[i_station]    = i_branch_offset;
                // A four-bit tag is already within a sixteen-entry reorder buffer.
                stn_tag[i_station]    = i_dest_tag;
            end
            REQ_TICK: begin
                if (!i_stall_hold) begin
                    resolve_tick();
                end
            end
            REQ_FLUSH: begin
                stage_now = '0;
            end
            default: begin
                // An unknown request leaves everything as it is.
            end
        endcase
    endtask

    // Compare one accepted result with the oldest predicted stage.
    task automatic compare_result();
        t_stage got;
        t_stage want;
        got = '{o_result_valid, o_branch_taken, o_target_addr, o_result_tag, o_picked_station};
        if (stage_queue.size() == 0) begin
            if (mismatch_count < 10) begin
                $display("%0t: result with no item waiting: valid=%0b taken=%0b target=%h tag=%0d st=%0d",
                         $realtime, got.valid, got.taken, got.target, got.tag, got.station);
            end
            mismatch_count++;
        end else begin
            want = stage_queue.pop_front();
            if (got.valid !== want.valid || got.taken !== want.taken ||
                got.target !== want.target || got.tag !== want.tag ||
                got.station !== want.station) begin
                if (mismatch_count < 10) begin
                    $display("%0t: result mismatch: expected valid=%0b taken=%0b target=%h tag=%0d st=%0d",
                             $realtime, want.valid, want.taken, want.target, want.tag,
                             want.station);
                    $display("%0t:                  actual valid=%0b taken=%0b target=%h tag=%0d st=%0d",
                             $realtime, got.valid, got.taken, got.target, got.tag, got.station);
                end
                mismatch_count++;
            end
        end
    endtask

    // Results are checked before the new item is predicted, as a result cannot come from it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_prediction();
            stage_queue.delete();
        end else begin
            if (o_valid && !i_stall) begin
                compare_result();
            end
            if (i_valid && !o_stall) begin
                apply_request();
                stage_queue.push_back(stage_now);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= stage_queue.size();
    end

endmodule

FILE: dv/tb_branch_unit_station_select_unit.sv
// Testbench top for the branch unit station select block: clock, reset, stimulus and verdict.
// Depends on bss_pkg, the block itself and branch_resolve_checker.
`timescale 1ns / 1ps

module tb_branch_unit_station_select_unit;
    import bss_pkg::*;

    localparam int DIRECTED_ITEMS = 22;
    localparam int RANDOM_ITEMS   = 800;

    // One request item with all of its fields.
    typedef struct packed {
        logic [REQ_W-1:0]     req;
        logic [STATION_W-1:0] station;
        logic [FLAGS_W-1:0]   flags;
        logic [VALUE_W-1:0]   src1;
        logic [VALUE_W-1:0]   src2;
        logic [VALUE_W-1:0]   base;
        logic [VALUE_W-1:0]   offset;
        logic [TAG_W-1:0]     tag;
        logic                 hold;
    } t_branch_req;

    // A station that is busy, has both operands and is issued.
    localparam logic [FLAGS_W-1:0] READY_FLAGS = FLAGS_W'((1 << FLAG_BUSY) | (1 << FLAG_SRC1_RDY) |
                                                          (1 << FLAG_SRC2_RDY) | (1 << FLAG_ISSUED));
    localparam logic [FLAGS_W-1:0] FRESH_FLAG  = FLAGS_W'(1 << FLAG_FRESH);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [REQ_W-1:0]      i_req_type;
    logic [STATION_W-1:0]  i_station;
    logic [FLAGS_W-1:0]    i_flags;
    logic [VALUE_W-1:0]    i_src1_value;
    logic [VALUE_W-1:0]    i_src2_value;
    logic [VALUE_W-1:0]    i_base_addr;
    logic signed [VALUE_W-1:0] i_branch_offset;
    logic [TAG_W-1:0]      i_dest_tag;
    logic                  i_stall_hold;
    logic                  o_valid;
    logic                  i_stall   = 1'b0;
    logic                  o_result_valid;
    logic                  o_branch_taken;
    logic [VALUE_W-1:0]    o_target_addr;
    logic [TAG_W-1:0]      o_result_tag;
    logic [STATION_W-1:0]  o_picked_station;

    int   mismatches;
    int   pending;
    int   n_sent    = 0;
    logic long_hold = 1'b0;
    bit   tx_burst  = 1'b0;
    bit   rx_burst  = 1'b0;
    int   rx_wait   = 0;
    int   rx_count  = 0;

    branch_unit_station_select_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_station        (i_station),
        .i_flags          (i_flags),
        .i_src1_value     (i_src1_value),
        .i_src2_value     (i_src2_value),
        .i_base_addr      (i_base_addr),
        .i_branch_offset  (i_branch_offset),
        .i_dest_tag       (i_dest_tag),
        .i_stall_hold     (i_stall_hold),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_valid   (o_result_valid),
        .o_branch_taken   (o_branch_taken),
        .o_target_addr    (o_target_addr),
        .o_result_tag     (o_result_tag),
        .o_picked_station (o_picked_station)
    );

    branch_resolve_checker u_resolve_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_station        (i_station),
        .i_flags          (i_flags),
        .i_src1_value     (i_src1_value),
        .i_src2_value     (i_src2_value),
        .i_base_addr      (i_base_addr),
        .i_branch_offset  (i_branch_offset),
        .i_dest_tag       (i_dest_tag),
        .i_stall_hold     (i_stall_hold),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_valid   (o_result_valid),
        .o_branch_taken   (o_branch_taken),
        .o_target_addr    (o_target_addr),
        .o_result_tag     (o_result_tag),
        .o_picked_station (o_picked_station),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // Clock with a 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fixed limit well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: a random stall after each accepted result, with bursts of none at all.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                rx_count++;
                if (rx_count % 64 == 0) begin
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
            end
            i_stall <= long_hold || (rx_wait > 0);
            if (rx_wait > 0) begin
                rx_wait--;
            end
        end
    end

    // Long hold-off on the result side so that the block fills up and stalls its input.
    initial begin
        wait (n_sent >= DIRECTED_ITEMS + 150);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    function automatic t_branch_req make_req(logic [REQ_W-1:0] req, logic [STATION_W-1:0] st,
                                             logic [FLAGS_W-1:0] flags, logic [VALUE_W-1:0] s1,
                                             logic [VALUE_W-1:0] s2, logic [VALUE_W-1:0] base,
                                             logic [VALUE_W-1:0] off, logic [TAG_W-1:0] tag,
                                             logic hold);
        t_branch_req r;
        r = '{req, st, flags, s1, s2, base, off, tag, hold};
        return r;
    endfunction

    function automatic t_branch_req make_tick(logic hold);
        return make_req(REQ_TICK, STATION_W'($urandom), FLAGS_W'($urandom), $urandom, $urandom,
                        $urandom, $urandom, TAG_W'($urandom), hold);
    endfunction

    // Offer one item, hold it until it is taken, then idle for a random gap.
    task automatic send_req(t_branch_req r);
        int gap;
        i_valid         <= 1'b1;
        i_req_type      <= r.req;
        i_station       <= r.station;
        i_flags         <= r.flags;
        i_src1_value    <= r.src1;
        i_src2_value    <= r.src2;
        i_base_addr     <= r.base;
        i_branch_offset <= r.offset;
        i_dest_tag      <= r.tag;
        i_stall_hold    <= r.hold;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
        if (n_sent % 64 == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
        end
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly station fills followed by ticks; the rest is noise of any request.
    task automatic send_random_burst();
        t_branch_req     r;
        logic [FLAGS_W-1:0] flags;
        logic [VALUE_W-1:0] s1;
        int              n_wr;
        int              n_tk;
        int              k;
        if ($urandom_range(0, 9) < 8) begin
            n_wr = $urandom_range(1, 4);
            for (k = 0; k < n_wr; k++) begin
                flags = READY_FLAGS;
                if ($urandom_range(0, 3) == 0) begin
                    flags = flags | FRESH_FLAG;
                end
                if ($urandom_range(0, 6) == 0) begin
                    flags = FLAGS_W'($urandom);
                end
                s1 = $urandom;
                r  = make_req(REQ_WRITE, STATION_W'($urandom), flags, s1,
                              ($urandom_range(0, 4) < 2) ? s1 : $urandom, $urandom, $urandom,
                              TAG_W'($urandom), 1'($urandom));
                send_req(r);
            end
            n_tk = $urandom_range(1, 6);
            for (k = 0; k < n_tk; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = make_tick(1'b0);
                    r.req = REQ_FLUSH;
                end else begin
                    r = make_tick($urandom_range(0, 5) == 0);
                end
                send_req(r);
            end
        end else begin
            r = make_req(REQ_W'($urandom), STATION_W'($urandom), FLAGS_W'($urandom), $urandom,
                         $urandom, $urandom, $urandom, TAG_W'($urandom), 1'($urandom));
            send_req(r);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_req_type      <= REQ_TICK;
        i_station       <= '0;
        i_flags         <= '0;
        i_src1_value    <= '0;
        i_src2_value    <= '0;
        i_base_addr     <= '0;
        i_branch_offset <= '0;
        i_dest_tag      <= '0;
        i_stall_hold    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Tick on an empty table: nothing is picked.
        send_req(make_tick(1'b0));
        // Every flag set: the fresh-operand mark costs one tick, then the branch is taken.
        send_req(make_req(REQ_WRITE, 2'd0, '1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                          32'h7FFF_FFFF, 4'd15, 1'b0));
        send_req(make_tick(1'b0));
        send_req(make_tick(1'b0));
        // The picked station is executing and is not picked again.
        send_req(make_tick(1'b0));
        // Equal operands fall through and the address wraps; most negative offset unused.
        send_req(make_req(REQ_WRITE, 2'd1, READY_FLAGS, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFC, 32'h8000_0000, 4'd0, 1'b1));
        send_req(make_req(REQ_WRITE, 2'd2, READY_FLAGS, 32'h0000_0001, 32'h0000_0002,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd5, 1'b0));
        send_req(make_req(REQ_WRITE, 2'd3, READY_FLAGS, 32'h0000_0000, 32'h0000_0000,
                          32'h1234_5678, 32'h0000_0010, 4'd9, 1'b0));
        // Held tick, then the round robin walks from the station after the last pick.
        send_req(make_tick(1'b1));
        send_req(make_tick(1'b0));
        send_req(make_req(REQ_FLUSH, 2'd3, '1, '1, '1, '1, '1, '1, 1'b1));
        send_req(make_req(2'd3, 2'd2, '1, '1, '0, '1, '0, '1, 1'b1));
        send_req(make_tick(1'b0));
        send_req(make_tick(1'b0));
        // Stations that are idle, short of an operand, or not yet issued are passed over.
        send_req(make_req(REQ_WRITE, 2'd0, '0, 32'h1, 32'h2, 32'h100, 32'h8, 4'd1, 1'b0));
        send_req(make_req(REQ_WRITE, 2'd1, READY_FLAGS & ~FLAGS_W'(1 << FLAG_SRC2_RDY),
                          32'h1, 32'h2, 32'h200, 32'h8, 4'd2, 1'b0));
        send_req(make_req(REQ_WRITE, 2'd2, READY_FLAGS & ~FLAGS_W'(1 << FLAG_ISSUED),
                          32'h1, 32'h2, 32'h300, 32'h8, 4'd3, 1'b0));
        send_req(make_tick(1'b0));
        // Taken branch whose target wraps to zero; a held tick must not pick it.
        send_req(make_req(REQ_WRITE, 2'd0, READY_FLAGS, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h8000_0000, 32'h8000_0000, 4'd10, 1'b0));
        send_req(make_tick(1'b1));
        send_req(make_tick(1'b0));
        send_req(make_req(REQ_FLUSH, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0));

        while (n_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            send_random_burst();
        end
        i_valid <= 1'b0;

        // Drain the outstanding results, then keep watching for anything unexpected.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bss_pkg.sv
rtl/core/bss_stations.sv
rtl/core/bss_resolve.sv
rtl/core/branch_unit_station_select_unit.sv
rtl/core/bss_checker.sv
dv/branch_resolve_checker.sv
dv/tb_branch_unit_station_select_unit.sv
